FILE: design/kcl_pkg.sv
// Package for the keypad combination lock core.
// Holds mode encoding, key codes, result codes and register indexes.
// No dependencies.
package kcl_pkg;

  localparam int unsigned CODE_LENGTH = 4;
  localparam int unsigned KEY_W       = 8;
  localparam int unsigned DIGIT_W     = 2;
  localparam int unsigned ATT_W       = 3;
  localparam int unsigned CODE_W      = CODE_LENGTH * KEY_W;

  typedef enum logic [2:0] {
    MODE_MENU     = 3'd0,
    MODE_ENTRY    = 3'd1,
    MODE_UNLOCKED = 3'd2,
    MODE_LOCKOUT  = 3'd3,
    MODE_REMOTE   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    LATCH_NONE = 2'd0,
    LATCH_OPEN = 2'd1,
    LATCH_LOCK = 2'd2
  } latch_e;

  typedef enum logic [2:0] {
    ST_IGNORED = 3'd0,
    ST_PROMPT  = 3'd1,
    ST_DIGIT   = 3'd2,
    ST_WELCOME = 3'd3,
    ST_WRONG   = 3'd4,
    ST_LOCKED  = 3'd5,
    ST_LOCKOUT = 3'd6,
    ST_WAITING = 3'd7
  } status_e;

  // Event source carried in tuser
  localparam logic SRC_KEYPAD = 1'b0;
  localparam logic SRC_SERIAL = 1'b1;

  // Register indexes on the configuration port
  localparam logic CFG_PASSWORD = 1'b0;
  localparam logic CFG_MAX_ATT  = 1'b1;

  // Key codes (ASCII)
  localparam logic [KEY_W-1:0] KEY_NONE  = 8'h00;
  localparam logic [KEY_W-1:0] KEY_ONE   = 8'h31;
  localparam logic [KEY_W-1:0] KEY_TWO   = 8'h32;
  localparam logic [KEY_W-1:0] KEY_C     = 8'h43;
  localparam logic [KEY_W-1:0] KEY_EQUAL = 8'h3D;
  localparam logic [KEY_W-1:0] KEY_L     = 8'h4C;
  localparam logic [KEY_W-1:0] KEY_U     = 8'h55;

  // Register reset values
  localparam logic [CODE_W-1:0] PASSWORD_RST = 32'h3132_3334;
  localparam logic [ATT_W-1:0]  MAX_ATT_RST  = 3'd3;

endpackage

FILE: design/keypad_combination_lock_fsm_core.sv
// Top level of the keypad combination lock core.
// Takes keypad and serial events, drives latch commands and status items.
// Depends on kcl_pkg.
//
// The core accepts one event item per clock while the result side is not
// stalled and returns exactly one result item per event, in order. An
// accepted event is held in an input register; the mode machine then
// evaluates it and writes the result register, updating its own state at
// the same edge. With the output side always ready, an item enters every
// cycle; its result passes from the input register into the result
// register, from which it can be taken. When the output stalls, the input
// register still takes one more item, so both registers fill before
// s_axis_tready drops. The four entered keys are compared in parallel with
// password_q when the fourth key arrives. Configuration writes are taken in
// any cycle (cfg_ready_o is tied high) but must only be issued while no
// item is in flight; a new max_attempts value takes effect at the next
// relock or lockout exit. Keys collected during entry have no reset value
// and the first three are compared only once written in the current entry.
module keypad_combination_lock_fsm_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // event stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] key_code
  input  logic                       s_axis_tuser,   // [0] op (1 = serial byte)
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [1:0] latch_cmd, [4:2] status, [7:5] attempts_left
  output logic [7:0]                 m_axis_tdata,
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [kcl_pkg::CODE_W-1:0] cfg_data_i
);

  // Configuration registers
  logic [kcl_pkg::CODE_W-1:0] password_q;
  logic [kcl_pkg::ATT_W-1:0]  max_att_q;

  // Input register
  logic                      in_valid_q;
  logic                      in_op_q;
  logic [kcl_pkg::KEY_W-1:0] in_key_q;

  // Mode machine state
  kcl_pkg::mode_e              mode_q, mode_d;
  logic [kcl_pkg::DIGIT_W-1:0] digit_q, digit_d;
  logic [kcl_pkg::ATT_W-1:0]   att_q, att_d;
  logic                        remote_q, remote_d;
  logic [kcl_pkg::KEY_W-1:0]   keys_q [kcl_pkg::CODE_LENGTH];
  logic                        key_wr;

  // Result register
  logic                       out_valid_q;
  kcl_pkg::latch_e            out_latch_q, latch_c;
  kcl_pkg::status_e           out_status_q, status_c;
  logic [kcl_pkg::ATT_W-1:0]  out_att_q;

  logic                       out_free;
  logic                       adv;
  logic                       keypad;
  logic                       serial;
  logic                       last_digit;
  logic                       code_match;
  logic [kcl_pkg::ATT_W-1:0]  att_dec;

  // Handshake: move the held item into the result register when it is free
  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_att_q, out_status_q, out_latch_q};

  // Event decode
  assign keypad     = (in_op_q == kcl_pkg::SRC_KEYPAD);
  assign serial     = (in_op_q == kcl_pkg::SRC_SERIAL);
  assign last_digit = (digit_q == kcl_pkg::DIGIT_W'(kcl_pkg::CODE_LENGTH - 1));

  // The fourth key is the one in the input register; compare it directly
  assign code_match = (keys_q[0] == password_q[31:24]) &&
                      (keys_q[1] == password_q[23:16]) &&
                      (keys_q[2] == password_q[15:8])  &&
                      (in_key_q  == password_q[7:0]);

  // Spend one attempt, saturating at zero
  assign att_dec = (att_q != '0) ? att_q - kcl_pkg::ATT_W'(1) : '0;

  // Next state
  always_comb begin
    mode_d   = mode_q;
    digit_d  = digit_q;
    att_d    = att_q;
    remote_d = remote_q;
    key_wr   = 1'b0;
    case (mode_q)
      kcl_pkg::MODE_MENU: begin
        if (keypad && in_key_q == kcl_pkg::KEY_ONE) begin
          digit_d = '0;
          mode_d  = (att_q == '0) ? kcl_pkg::MODE_LOCKOUT : kcl_pkg::MODE_ENTRY;
        end else if (keypad && in_key_q == kcl_pkg::KEY_TWO) begin
          mode_d   = kcl_pkg::MODE_REMOTE;
          remote_d = 1'b0;
        end
      end
      kcl_pkg::MODE_ENTRY: begin
        if (keypad && in_key_q != kcl_pkg::KEY_NONE) begin
          key_wr = 1'b1;
          if (!last_digit) begin
            digit_d = digit_q + kcl_pkg::DIGIT_W'(1);
          end else begin
            digit_d = '0;
            if (code_match) begin
              mode_d = kcl_pkg::MODE_UNLOCKED;
            end else begin
              att_d = att_dec;
              if (att_dec == '0) begin
                mode_d = kcl_pkg::MODE_LOCKOUT;
              end
            end
          end
        end
      end
      kcl_pkg::MODE_UNLOCKED: begin
        if (keypad && in_key_q == kcl_pkg::KEY_C) begin
          mode_d = kcl_pkg::MODE_MENU;
          att_d  = max_att_q;
        end
      end
      kcl_pkg::MODE_LOCKOUT: begin
        if (keypad && in_key_q == kcl_pkg::KEY_EQUAL) begin
          mode_d = kcl_pkg::MODE_MENU;
          att_d  = max_att_q;
        end
      end
      kcl_pkg::MODE_REMOTE: begin
        if (serial && in_key_q == kcl_pkg::KEY_U) begin
          remote_d = 1'b1;
        end else if (serial && in_key_q == kcl_pkg::KEY_L && remote_q) begin
          remote_d = 1'b0;
          mode_d   = kcl_pkg::MODE_MENU;
        end
      end
      default: begin
        mode_d = kcl_pkg::MODE_MENU;
      end
    endcase
  end

  // Result codes for the held item
  always_comb begin
    latch_c  = kcl_pkg::LATCH_NONE;
    status_c = kcl_pkg::ST_IGNORED;
    case (mode_q)
      kcl_pkg::MODE_MENU: begin
        if (keypad && in_key_q == kcl_pkg::KEY_ONE) begin
          status_c = (att_q == '0) ? kcl_pkg::ST_LOCKOUT : kcl_pkg::ST_PROMPT;
        end else if (keypad && in_key_q == kcl_pkg::KEY_TWO) begin
          status_c = kcl_pkg::ST_WAITING;
        end
      end
      kcl_pkg::MODE_ENTRY: begin
        if (keypad && in_key_q != kcl_pkg::KEY_NONE) begin
          if (!last_digit) begin
            status_c = kcl_pkg::ST_DIGIT;
          end else if (code_match) begin
            latch_c  = kcl_pkg::LATCH_OPEN;
            status_c = kcl_pkg::ST_WELCOME;
          end else begin
            status_c = (att_dec == '0) ? kcl_pkg::ST_LOCKOUT : kcl_pkg::ST_WRONG;
          end
        end
      end
      kcl_pkg::MODE_UNLOCKED: begin
        if (keypad && in_key_q == kcl_pkg::KEY_C) begin
          latch_c  = kcl_pkg::LATCH_LOCK;
          status_c = kcl_pkg::ST_LOCKED;
        end
      end
      kcl_pkg::MODE_LOCKOUT: begin
        if (keypad && in_key_q == kcl_pkg::KEY_EQUAL) begin
          status_c = kcl_pkg::ST_LOCKED;
        end
      end
      kcl_pkg::MODE_REMOTE: begin
        if (serial && in_key_q == kcl_pkg::KEY_U) begin
          latch_c  = kcl_pkg::LATCH_OPEN;
          status_c = kcl_pkg::ST_WELCOME;
        end else if (serial && in_key_q == kcl_pkg::KEY_L && remote_q) begin
          latch_c  = kcl_pkg::LATCH_LOCK;
          status_c = kcl_pkg::ST_LOCKED;
        end
      end
      default: begin
        latch_c  = kcl_pkg::LATCH_NONE;
        status_c = kcl_pkg::ST_IGNORED;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      password_q <= kcl_pkg::PASSWORD_RST;
      max_att_q  <= kcl_pkg::MAX_ATT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        kcl_pkg::CFG_PASSWORD: password_q <= cfg_data_i;
        kcl_pkg::CFG_MAX_ATT:  max_att_q  <= cfg_data_i[kcl_pkg::ATT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: load on accept, drop when the item advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q  <= s_axis_tuser;
      in_key_q <= s_axis_tdata;
    end
  end

  // Mode machine state: advance with each evaluated item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= kcl_pkg::MODE_MENU;
      digit_q  <= '0;
      att_q    <= kcl_pkg::MAX_ATT_RST;
      remote_q <= 1'b0;
    end else if (adv) begin
      mode_q   <= mode_d;
      digit_q  <= digit_d;
      att_q    <= att_d;
      remote_q <= remote_d;
    end
  end

  // Entered keys, no reset
  always_ff @(posedge clk_i) begin
    if (adv && key_wr) begin
      keys_q[digit_q] <= in_key_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_latch_q  <= latch_c;
      out_status_q <= status_c;
      out_att_q    <= att_d;
    end
  end

  // Lockout is only reached with no attempts left
  a_lockout_no_attempts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == kcl_pkg::MODE_LOCKOUT) |-> (att_q == '0))
    else $error("lockout with attempts remaining");

  // Digit count is cleared whenever entry is not in progress
  a_digit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != kcl_pkg::MODE_ENTRY) |-> (digit_q == '0))
    else $error("digit count nonzero outside entry");

  // Remote unlock flag lives only inside a remote session
  a_remote_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remote_q |-> (mode_q == kcl_pkg::MODE_REMOTE))
    else $error("remote flag set outside remote mode");

  // A held item waits in the input register while the result side is blocked
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(in_key_q) && $stable(mode_q)))
    else $error("held item lost or state moved during stall");

endmodule
